// ===== rtl/mtbd_pkg.sv =====
// Shared constants and controller/datapath interface types for the bounded MT draw core.
`timescale 1ns / 1ps
package mtbd_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int ADDR_W       = $clog2(STATE_WORDS);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h80000000;
  localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] SEED_MULT    = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;

  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] IDX_SPENT = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] IDX_NEVER = ADDR_W'(STATE_WORDS + 1);

  localparam logic ACT_SEED = 1'b0;

  typedef struct packed {
    logic load_in;
    logic fill_start_seed;
    logic fill_start_default;
    logic fill_step;
    logic tw_load;
    logic tw_hi;
    logic tw_rd;
    logic tw_wr;
    logic fetch_rd;
    logic temper;
    logic div_step;
    logic out_zero;
    logic out_rem;
  } ctrl_cmd_t;

  typedef struct packed {
    logic action;
    logic bound_zero;
    logic idx_never;
    logic idx_spent;
    logic cnt_last_word;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/mersenne_twister_bounded_draw_core.sv =====
// Top level of the MT19937 bounded draw core (Knuth 69069 seeding).
`timescale 1ns / 1ps
// MT19937 generator with a bounded draw. An input transfer with action 0 reseeds
// the 624-word state from seed (word i = 69069 * word i-1, mod 2^32) and returns
// value 0. An input transfer with action 1 draws: bound 0 returns 0 and leaves the
// state alone; otherwise the block seeds with 4357 if never seeded, regenerates
// all words when the 624 words are used up, tempers the next word and returns it
// modulo bound. One item is in work at a time; in_ready is high while idle, and a
// finished result waits in the output register without blocking the next accept.
// Sequencing follows the single-write state RAM and the bit-serial remainder unit:
// reseed makes one RAM write per word; a draw runs a 32-step restoring remainder
// after fetch and temper; a draw that needs a twist first reads, mixes and writes
// back every word, and a first draw after reset runs the default seed fill as
// well.
module mersenne_twister_bounded_draw_core
  import mtbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] seed,
  input  logic [31:0] bound,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencing: fill, twist, fetch/temper, divide, result transfer
  mtbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // state RAM, arithmetic and the output register
  mtbd_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .action   (action),
    .seed     (seed),
    .bound    (bound),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value    (value)
  );

endmodule

// ===== rtl/mtbd_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module mtbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/mtbd_datapath.sv =====
// Datapath: state RAM, seed chain, twist mix, tempering, remainder divider, output register.
`timescale 1ns / 1ps
module mtbd_datapath
  import mtbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  sts,
  input  logic        action,
  input  logic [31:0] seed,
  input  logic [31:0] bound,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);

  logic              action_r;
  logic [31:0]       seed_r;
  logic [31:0]       bound_r;
  logic [ADDR_W-1:0] word_index;
  logic [ADDR_W-1:0] cnt;
  logic [31:0]       chain;
  logic [31:0]       dv;
  logic [31:0]       rem;

  logic              we;
  logic [31:0]       wdata;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [31:0]       rdata_a;
  logic [31:0]       rdata_b;
  logic [ADDR_W-1:0] nxt_addr;
  logic [ADDR_W-1:0] far_addr;
  logic [31:0]       mixed;
  logic [31:0]       mix_y;
  logic [31:0]       t1;
  logic [31:0]       t2;
  logic [31:0]       t3;
  logic [31:0]       tempered;
  logic [32:0]       trial;
  logic [32:0]       trial_sub;

  mtbd_ram #(
    .WIDTH(32),
    .DEPTH(STATE_WORDS)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (cnt),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  // twist neighbors of word cnt
  assign nxt_addr = (cnt == LAST_WORD) ? '0 : cnt + 1'b1;
  assign far_addr = (cnt < ADDR_W'(STATE_WORDS - SHIFT_OFFSET)) ?
                    cnt + ADDR_W'(SHIFT_OFFSET) :
                    cnt - ADDR_W'(STATE_WORDS - SHIFT_OFFSET);

  assign mix_y = (chain & HIGH_BIT) | (rdata_a & LOW_BITS);
  assign mixed = rdata_b ^ (mix_y >> 1) ^ (mix_y[0] ? TWIST_MATRIX : 32'd0);

  assign t1       = rdata_a ^ (rdata_a >> 11);
  assign t2       = t1 ^ ((t1 << 7) & TEMPER_B);
  assign t3       = t2 ^ ((t2 << 15) & TEMPER_C);
  assign tempered = t3 ^ (t3 >> 18);

  assign trial     = {rem, dv[31]};
  assign trial_sub = trial - {1'b0, bound_r};

  always_comb begin
    we      = cmd.fill_step | cmd.tw_wr;
    wdata   = cmd.tw_wr ? mixed : chain;
    raddr_a = '0;
    if (cmd.tw_rd) begin
      raddr_a = nxt_addr;
    end else if (cmd.fetch_rd) begin
      raddr_a = word_index;
    end
    raddr_b = far_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= IDX_NEVER;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.fill_step && cnt == LAST_WORD) begin
        word_index <= IDX_SPENT;
      end else if (cmd.tw_wr && cnt == LAST_WORD) begin
        word_index <= '0;
      end else if (cmd.fetch_rd) begin
        word_index <= word_index + 1'b1;
      end
      if (cmd.out_zero || cmd.out_rem) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r <= action;
      seed_r   <= seed;
      bound_r  <= bound;
    end
    if (cmd.fill_start_seed) begin
      chain <= seed_r;
      cnt   <= '0;
    end else if (cmd.fill_start_default) begin
      chain <= DEFAULT_SEED;
      cnt   <= '0;
    end else if (cmd.fill_step) begin
      chain <= chain * SEED_MULT;
      cnt   <= cnt + 1'b1;
    end else if (cmd.tw_load) begin
      cnt <= '0;
    end else if (cmd.tw_hi) begin
      chain <= rdata_a;
    end else if (cmd.tw_wr) begin
      chain <= rdata_a;
      cnt   <= cnt + 1'b1;
    end else if (cmd.temper) begin
      dv  <= tempered;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
      dv  <= dv << 1;
      cnt <= cnt + 1'b1;
    end
    if (cmd.out_zero) begin
      value <= '0;
    end else if (cmd.out_rem) begin
      value <= rem;
    end
  end

  always_comb begin
    sts.action        = action_r;
    sts.bound_zero    = (bound_r == '0);
    sts.idx_never     = (word_index == IDX_NEVER);
    sts.idx_spent     = (word_index >= IDX_SPENT);
    sts.cnt_last_word = (cnt == LAST_WORD);
    sts.div_last      = (cnt[4:0] == 5'd31);
    sts.out_busy      = out_valid & ~out_ready;
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    word_index <= IDX_NEVER)
    else $error("word index beyond never-seeded mark");

  a_fetch_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch_rd |-> word_index < IDX_SPENT)
    else $error("fetch from spent state");

  a_twist_resets_index: assert property (@(posedge clk) disable iff (rst)
    (cmd.tw_wr && cnt == LAST_WORD) |=> word_index == '0)
    else $error("index not rewound after twist");

  a_rem_below_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < bound_r)
    else $error("partial remainder not below bound");

endmodule

// ===== rtl/mtbd_ctrl.sv =====
// Controller state machine sequencing seed fill, twist, fetch and divide.
`timescale 1ns / 1ps
module mtbd_ctrl
  import mtbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_FILL, S_TW_LOAD, S_TW_HI, S_TW_RD, S_TW_WR,
    S_FETCH, S_TEMPER, S_DIVIDE, S_FIN_ZERO, S_FIN_REM
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts.action == ACT_SEED) state <= S_FILL;
          else if (sts.bound_zero) state <= S_FIN_ZERO;
          else if (sts.idx_never) state <= S_FILL;
          else if (sts.idx_spent) state <= S_TW_LOAD;
          else state <= S_FETCH;
        end
        S_FILL: begin
          if (sts.cnt_last_word) begin
            state <= (sts.action == ACT_SEED) ? S_FIN_ZERO : S_TW_LOAD;
          end
        end
        S_TW_LOAD: state <= S_TW_HI;
        S_TW_HI:   state <= S_TW_RD;
        S_TW_RD:   state <= S_TW_WR;
        S_TW_WR: begin
          state <= sts.cnt_last_word ? S_FETCH : S_TW_RD;
        end
        S_FETCH:  state <= S_TEMPER;
        S_TEMPER: state <= S_DIVIDE;
        S_DIVIDE: begin
          if (sts.div_last) state <= S_FIN_REM;
        end
        S_FIN_ZERO, S_FIN_REM: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd                    = '0;
    cmd.load_in            = (state == S_IDLE) && in_valid;
    cmd.fill_start_seed    = (state == S_DECIDE) && (sts.action == ACT_SEED);
    cmd.fill_start_default = (state == S_DECIDE) && (sts.action != ACT_SEED) &&
                             !sts.bound_zero && sts.idx_never;
    cmd.fill_step          = (state == S_FILL);
    cmd.tw_load            = (state == S_TW_LOAD);
    cmd.tw_hi              = (state == S_TW_HI);
    cmd.tw_rd              = (state == S_TW_RD);
    cmd.tw_wr              = (state == S_TW_WR);
    cmd.fetch_rd           = (state == S_FETCH);
    cmd.temper             = (state == S_TEMPER);
    cmd.div_step           = (state == S_DIVIDE);
    cmd.out_zero           = (state == S_FIN_ZERO) && !sts.out_busy;
    cmd.out_rem            = (state == S_FIN_REM) && !sts.out_busy;
  end

  a_single_out_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.out_zero && cmd.out_rem))
    else $error("two result loads at once");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == S_DECIDE)
    else $error("accept did not start decode");

  a_fill_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fill_start_seed && cmd.fill_start_default))
    else $error("two fill starts at once");

endmodule
